>>> design/hps_pkg.sv
// ----------------------------------------------------------------------------
// hps_pkg
// Shared types, sizes and helpers for the Hartley power spectrum core.
// ----------------------------------------------------------------------------
package hps_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int COEF_BITS  = 16;

    localparam int DEPTH     = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_BITS = $clog2(DEPTH);

    localparam int CFG_BITS       = 9;
    localparam int CFG_INDEX_BITS = 1;
    localparam int W_DIM_BITS     = $clog2(MAX_WIDTH + 1);
    localparam int H_DIM_BITS     = $clog2(MAX_HEIGHT + 1);
    localparam int DIM_BITS0      = (W_DIM_BITS > H_DIM_BITS) ? W_DIM_BITS : H_DIM_BITS;
    localparam int DIM_BITS       = (DIM_BITS0 > CFG_BITS) ? DIM_BITS0 : CFG_BITS;

    localparam int SQ_BITS    = 2 * COEF_BITS;
    localparam int POWER_BITS = 31;
    localparam logic [63:0] POWER_MAX = 64'h0000_0000_7FFF_FFFF;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_WIDTH  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HEIGHT = CFG_INDEX_BITS'(1);

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic               op;
        logic [7:0]         col;
        logic [7:0]         row;
        logic signed [15:0] coefficient;
    } t_in_item;

    typedef struct packed {
        logic [POWER_BITS-1:0] power;
        logic                  range_error;
    } t_out_item;

    typedef struct packed {
        logic vld;
        logic err;
    } t_tag;

    function automatic logic signed [COEF_BITS-1:0] to_coef(input logic signed [15:0] c);
        return COEF_BITS'(c);
    endfunction

endpackage

>>> design/hartley_power_spectrum_core.sv
// ----------------------------------------------------------------------------
// hartley_power_spectrum_core
// Coefficient frame store with power-spectrum queries over the mirror pair.
// Flow: a query beat reads its coefficient, then its mirror coefficient; both are
// squared, then half-summed into the registered result and strobe. A load beat gives no result.
// Throughput: a load every cycle while not busy; a query holds busy for one cycle (second read
// on the single-port store), and no beat is taken while busy. No backpressure on the result output.
// Reset: sizes return to 256 and the pipeline empties; the store is not cleared.
// ----------------------------------------------------------------------------
module hartley_power_spectrum_core import hps_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  t_in_item                  i_item,
    output logic                      o_result_strobe,
    output t_out_item                 o_result,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_BITS-1:0]       i_cfg_data
);

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_MIRROR = 1'b1;

    logic [CFG_BITS-1:0]         r_width_used;
    logic [CFG_BITS-1:0]         r_height_used;
    logic                        r_state;
    t_tag                        r_tag1;
    t_tag                        r_tag2;
    logic [ADDR_BITS-1:0]        r_maddr;
    logic signed [COEF_BITS-1:0] r_a;

    logic [DIM_BITS-1:0]   w;
    logic [DIM_BITS-1:0]   h;
    logic [DIM_BITS-1:0]   u;
    logic [DIM_BITS-1:0]   v;
    logic [DIM_BITS-1:0]   mu;
    logic [DIM_BITS-1:0]   mv;
    logic                  in_frame;
    logic                  accept;
    logic [ADDR_BITS-1:0]  addr;
    logic [ADDR_BITS-1:0]  n_maddr;
    logic                  ram_en;
    logic                  ram_we;
    logic [ADDR_BITS-1:0]  ram_addr;
    logic [COEF_BITS-1:0]  ram_rdata;
    t_tag                  n_tag1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_used  <= CFG_BITS'(256);
            r_height_used <= CFG_BITS'(256);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WIDTH:  r_width_used  <= i_cfg_data;
                CFG_HEIGHT: r_height_used <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w = (DIM_BITS'(r_width_used) > DIM_BITS'(MAX_WIDTH))
            ? DIM_BITS'(MAX_WIDTH) : DIM_BITS'(r_width_used);
        h = (DIM_BITS'(r_height_used) > DIM_BITS'(MAX_HEIGHT))
            ? DIM_BITS'(MAX_HEIGHT) : DIM_BITS'(r_height_used);
        u        = DIM_BITS'(i_item.col);
        v        = DIM_BITS'(i_item.row);
        in_frame = (u < w) && (v < h);
        mu       = (u == '0) ? '0 : (w - u);
        mv       = (v == '0) ? '0 : (h - v);
        addr     = ADDR_BITS'(v) * ADDR_BITS'(MAX_WIDTH) + ADDR_BITS'(u);
        n_maddr  = ADDR_BITS'(mv) * ADDR_BITS'(MAX_WIDTH) + ADDR_BITS'(mu);
    end

    assign busy   = (r_state == S_MIRROR);
    assign accept = start && !busy;

    always_comb begin
        if (r_state == S_MIRROR) begin
            ram_en   = !r_tag1.err;
            ram_we   = 1'b0;
            ram_addr = r_maddr;
        end else begin
            ram_en   = accept && in_frame;
            ram_we   = (i_item.op == OP_LOAD);
            ram_addr = addr;
        end
        n_tag1.vld = accept && (i_item.op == OP_QUERY);
        n_tag1.err = !in_frame;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tag1  <= '0;
            r_tag2  <= '0;
        end else begin
            r_state <= n_tag1.vld ? S_MIRROR : S_IDLE;
            r_tag1  <= n_tag1;
            r_tag2  <= (r_state == S_MIRROR) ? r_tag1 : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_maddr <= n_maddr;
        end
        if (r_state == S_MIRROR) begin
            r_a <= ram_rdata;
        end
    end

    hps_coef_ram #(
        .DEPTH     (DEPTH),
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (COEF_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (to_coef(i_item.coefficient)),
        .o_rdata (ram_rdata)
    );

    hps_power_calc u_calc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tag    (r_tag2),
        .i_a      (r_a),
        .i_b      (ram_rdata),
        .o_strobe (o_result_strobe),
        .o_result (o_result)
    );

    a_busy_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held longer than one cycle");

    a_query_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_item.op == OP_QUERY) |-> ##4 o_result_strobe)
        else $error("query beat without result");

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_item.op == OP_LOAD) |-> ##4 !o_result_strobe)
        else $error("load beat produced a result");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_result.range_error) |-> (o_result.power == '0))
        else $error("range error with nonzero power");

endmodule

>>> design/hps_coef_ram.sv
// ----------------------------------------------------------------------------
// hps_coef_ram
// Single-port synchronous RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module hps_coef_ram #(
    parameter int DEPTH     = 65536,
    parameter int ADDR_BITS = 16,
    parameter int DATA_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_addr,
    input  logic [DATA_BITS-1:0] i_wdata,
    output logic [DATA_BITS-1:0] o_rdata
);

    logic [DATA_BITS-1:0] r_mem [DEPTH];
    logic [DATA_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/hps_power_calc.sv
// ----------------------------------------------------------------------------
// hps_power_calc
// Two-stage power unit: square both coefficients, then half-sum and saturate.
// ----------------------------------------------------------------------------
module hps_power_calc import hps_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_tag                        i_tag,
    input  logic signed [COEF_BITS-1:0] i_a,
    input  logic signed [COEF_BITS-1:0] i_b,
    output logic                        o_strobe,
    output t_out_item                   o_result
);

    logic signed [SQ_BITS-1:0] n_sq_a;
    logic signed [SQ_BITS-1:0] n_sq_b;
    logic [SQ_BITS-1:0]        r_sq_a;
    logic [SQ_BITS-1:0]        r_sq_b;
    t_tag                      r_tag;
    logic [SQ_BITS:0]          n_sum;
    logic [63:0]               n_half;
    t_out_item                 n_result;
    t_out_item                 r_result;
    logic                      r_strobe;

    assign n_sq_a = SQ_BITS'(i_a) * SQ_BITS'(i_a);
    assign n_sq_b = SQ_BITS'(i_b) * SQ_BITS'(i_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq_a <= n_sq_a;
        r_sq_b <= n_sq_b;
    end

    always_comb begin
        n_sum  = (SQ_BITS + 1)'(r_sq_a) + (SQ_BITS + 1)'(r_sq_b);
        n_half = 64'(n_sum >> 1);
        n_result.range_error = r_tag.err;
        if (r_tag.err) begin
            n_result.power = '0;
        end else if (n_half > POWER_MAX) begin
            n_result.power = POWER_MAX[POWER_BITS-1:0];
        end else begin
            n_result.power = n_half[POWER_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_tag.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
